/* hw/rtl/abps_pkg.sv */
// Shared types and constants for the ABS brake pressure step block.
// Used by abps_cfg and abs_brake_pressure_step; depends on nothing else.
package abps_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int TGT_W      = 7;
  localparam int PRES_W     = 8;
  localparam int MODE_W     = 2;
  localparam int SLIP_W     = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_TGT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ICE_TGT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRES   = 3'd4;

  localparam logic [TGT_W-1:0]  RST_NORMAL_TGT = 7'd15;
  localparam logic [TGT_W-1:0]  RST_ICE_TGT    = 7'd5;
  localparam logic [PRES_W-1:0] RST_STEP_UP    = 8'd20;
  localparam logic [PRES_W-1:0] RST_STEP_DOWN  = 8'd40;
  localparam logic [PRES_W-1:0] RST_MAX_PRES   = 8'd255;

  // Slip magnitude limit in percent
  localparam logic [TGT_W-1:0] SLIP_MAX = 7'd100;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_FAULT    = 2'd1,
    MODE_RECOVERY = 2'd2
  } mode_t;

  typedef struct packed {
    logic [TGT_W-1:0]  normal_tgt;
    logic [TGT_W-1:0]  ice_tgt;
    logic [PRES_W-1:0] step_up;
    logic [PRES_W-1:0] step_down;
    logic [PRES_W-1:0] max_pres;
  } cfg_t;

endpackage

/* hw/rtl/abps_cfg.sv */
// Configuration register bank for the ABS brake pressure step block.
// Depends on abps_pkg for register indexes, reset values and cfg_t.
module abps_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [abps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [abps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output abps_pkg::cfg_t                   cfg
);
  import abps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_NORMAL_TGT: cfg_nxt.normal_tgt = cfg_wdata[TGT_W-1:0];
        CFG_ICE_TGT:    cfg_nxt.ice_tgt    = cfg_wdata[TGT_W-1:0];
        CFG_STEP_UP:    cfg_nxt.step_up    = cfg_wdata[PRES_W-1:0];
        CFG_STEP_DOWN:  cfg_nxt.step_down  = cfg_wdata[PRES_W-1:0];
        CFG_MAX_PRES:   cfg_nxt.max_pres   = cfg_wdata[PRES_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_tgt <= RST_NORMAL_TGT;
      cfg_r.ice_tgt    <= RST_ICE_TGT;
      cfg_r.step_up    <= RST_STEP_UP;
      cfg_r.step_down  <= RST_STEP_DOWN;
      cfg_r.max_pres   <= RST_MAX_PRES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/abps_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, NUM_W quotient bits.
// Standalone; used by abs_brake_pressure_step for the slip quotient.
module abps_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // Shift the next dividend bit into the partial remainder
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CNT_W'(NUM_W);
      num_nxt = num;
      den_nxt = den;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      num_nxt = {num_r[NUM_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = cnt_r != '0;
  assign quo  = num_r;

endmodule

/* hw/rtl/abs_brake_pressure_step.sv */
// ABS brake pressure step: top level with control sequencer and output register.
// Depends on abps_pkg, abps_cfg and abps_div.
//
// Usage:
//   Input channel in_*: one transaction per control tick carrying wheel and
//   vehicle speed, brake request, ice flag and fault flag. Output channel
//   out_*: one transaction per input with the new pressure, the mode after
//   the tick and the slip percent. Both use valid/ready.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 normal
//   slip target, 1 ice slip target, 2 step up, 3 step down, 4 max pressure);
//   indexes past the list are ignored. Write only while the block is idle.
//   Timing: the slip quotient comes from a bit-serial divider that produces
//   one quotient bit per cycle over SPEED_BITS+7 bits. Input is taken only
//   in the idle state, so a new transaction is accepted only after the
//   previous one has left its final step.
//   Stall: a result waits in the output register; the next item is accepted
//   and divided meanwhile, and holds in its final step until the output frees.
//   Reset (rst_n low, synchronous): pressure 0, normal mode, configuration at
//   its reset values, both channels empty.
module abs_brake_pressure_step #(
  parameter int SPEED_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SPEED_BITS-1:0]             in_wheel_speed,
  input  logic [SPEED_BITS-1:0]             in_vehicle_speed,
  input  logic [abps_pkg::PRES_W-1:0]       in_brake_request,
  input  logic                              in_ice_mode,
  input  logic                              in_system_fault,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [abps_pkg::PRES_W-1:0]       out_pressure,
  output logic [abps_pkg::MODE_W-1:0]       out_abs_mode,
  output logic signed [abps_pkg::SLIP_W-1:0] out_slip_percent,
  input  logic                              cfg_we,
  input  logic [abps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [abps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import abps_pkg::*;

  // 100 * (2^SPEED_BITS - 1) fits in SPEED_BITS + 7 bits
  localparam int NUM_W = SPEED_BITS + 7;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  cfg_t   cfg;
  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [PRES_W-1:0] last_pres_r, last_pres_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [PRES_W-1:0] req_r;
  logic              ice_r;
  logic              fault_r;
  logic              neg_r;
  logic              vzero_r;

  logic [PRES_W-1:0] out_pres_r;
  logic [MODE_W-1:0] out_mode_r;
  logic [SLIP_W-1:0] out_slip_r;

  logic                  accept;
  logic                  commit;
  logic                  in_neg;
  logic [SPEED_BITS-1:0] diff;
  logic [NUM_W-1:0]      num;
  logic                  div_busy;
  logic [NUM_W-1:0]      quo;

  logic [TGT_W-1:0]  q_sat;
  logic [TGT_W-1:0]  target;
  logic              over;
  logic [PRES_W:0]   up_sum;
  logic              dn_ok;
  logic [PRES_W-1:0] dn_val;
  logic [PRES_W:0]   p_raw;
  logic [PRES_W-1:0] p_req;
  logic [PRES_W-1:0] p_fin;
  logic [SLIP_W-1:0] slip_fin;

  abps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Dividend is 100 * |v - w|, built from shifted copies
  assign in_neg = in_wheel_speed > in_vehicle_speed;
  assign diff   = in_neg ? (in_wheel_speed - in_vehicle_speed)
                         : (in_vehicle_speed - in_wheel_speed);
  assign num    = (NUM_W'(diff) << 6) + (NUM_W'(diff) << 5) + (NUM_W'(diff) << 2);

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;

  abps_div #(
    .NUM_W (NUM_W),
    .DEN_W (SPEED_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .num   (num),
    .den   (in_vehicle_speed),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Final step: pressure update, clamps and slip report
  assign q_sat  = (quo >= NUM_W'(SLIP_MAX)) ? SLIP_MAX : quo[TGT_W-1:0];
  assign target = ice_r ? cfg.ice_tgt : cfg.normal_tgt;
  assign over   = !neg_r && !vzero_r && (q_sat > target);
  assign up_sum = {1'b0, last_pres_r} + {1'b0, cfg.step_up};
  assign dn_ok  = last_pres_r >= cfg.step_down;
  assign dn_val = last_pres_r - cfg.step_down;

  always_comb begin
    if (fault_r) begin
      p_raw = {1'b0, req_r};
    end else if (req_r == '0) begin
      p_raw = '0;
    end else if (over) begin
      p_raw = dn_ok ? {1'b0, dn_val} : '0;
    end else begin
      p_raw = up_sum;
    end
  end

  assign p_req = (p_raw > {1'b0, req_r}) ? req_r : p_raw[PRES_W-1:0];
  assign p_fin = (p_req > cfg.max_pres) ? cfg.max_pres : p_req;

  always_comb begin
    if (fault_r || vzero_r) begin
      slip_fin = '0;
    end else if (neg_r) begin
      slip_fin = SLIP_W'(0) - {1'b0, q_sat};
    end else begin
      slip_fin = {1'b0, q_sat};
    end
  end

  always_comb begin
    if (fault_r) begin
      mode_nxt = MODE_FAULT;
    end else if (mode_r == MODE_FAULT) begin
      mode_nxt = MODE_RECOVERY;
    end else begin
      mode_nxt = mode_r;
    end
  end

  // Hold the final step while the previous result is still unread
  assign commit = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_DIV;
      S_DIV:   if (!div_busy) state_nxt = S_FIN;
      S_FIN:   if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    last_pres_nxt = last_pres_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      last_pres_nxt = p_fin;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_NORMAL;
      last_pres_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_pres_r <= last_pres_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_brake_request;
      ice_r   <= in_ice_mode;
      fault_r <= in_system_fault;
      neg_r   <= in_neg;
      vzero_r <= in_vehicle_speed == '0;
    end
    if (commit) begin
      out_pres_r <= p_fin;
      out_mode_r <= mode_nxt;
      out_slip_r <= slip_fin;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pressure     = out_pres_r;
  assign out_abs_mode     = out_mode_r;
  assign out_slip_percent = $signed(out_slip_r);

`ifndef SYNTH
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");

  a_fault_slip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_mode_r == MODE_FAULT)) |-> (out_slip_r == '0))
    else $error("nonzero slip reported in fault mode");

  a_slip_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (($signed(out_slip_r) >= -100) && ($signed(out_slip_r) <= 100)))
    else $error("slip out of range");
`endif

endmodule

/* dv/tb_abs_brake_pressure_step.sv */
`timescale 1ns / 100ps
// Self-checking testbench for abs_brake_pressure_step: control ticks and register writes
// go in, a behavioral predictor tracks pressure and mode, and every result is compared.
// Depends on abps_pkg and the RTL of abs_brake_pressure_step.
module tb_abs_brake_pressure_step;
  import abps_pkg::*;

  localparam int SPEED_BITS  = 10;
  localparam int SPD_MAX     = (1 << SPEED_BITS) - 1;
  localparam int SETTLE      = SPEED_BITS + 12;
  localparam int HOLD_CYCLES = 150;
  // Slowest legal gap between transactions is the output hold-off above.
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_PRINTS  = 50;

  typedef struct packed {
    logic [SPEED_BITS-1:0] wheel;
    logic [SPEED_BITS-1:0] vehicle;
    logic [PRES_W-1:0]     req;
    logic                  ice;
    logic                  fault;
  } tick_t;

  typedef struct {
    logic [PRES_W-1:0]        pressure;
    mode_t                    mode;
    logic signed [SLIP_W-1:0] slip;
  } brake_cmd_t;

  logic                         clk              = 1'b0;
  logic                         rst_n            = 1'b0;
  logic                         in_valid         = 1'b0;
  logic                         in_ready;
  logic [SPEED_BITS-1:0]        in_wheel_speed   = '0;
  logic [SPEED_BITS-1:0]        in_vehicle_speed = '0;
  logic [PRES_W-1:0]            in_brake_request = '0;
  logic                         in_ice_mode      = 1'b0;
  logic                         in_system_fault  = 1'b0;
  logic                         out_valid;
  logic                         out_ready        = 1'b0;
  logic [PRES_W-1:0]            out_pressure;
  logic [MODE_W-1:0]            out_abs_mode;
  logic signed [SLIP_W-1:0]     out_slip_percent;
  logic                         cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index        = '0;
  logic [CFG_DATA_W-1:0]        cfg_wdata        = '0;

  abs_brake_pressure_step #(
    .SPEED_BITS(SPEED_BITS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_wheel_speed   (in_wheel_speed),
    .in_vehicle_speed (in_vehicle_speed),
    .in_brake_request (in_brake_request),
    .in_ice_mode      (in_ice_mode),
    .in_system_fault  (in_system_fault),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pressure     (out_pressure),
    .out_abs_mode     (out_abs_mode),
    .out_slip_percent (out_slip_percent),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Shadow copy of the block's registers and state
  cfg_t              regs_sh = '{RST_NORMAL_TGT, RST_ICE_TGT, RST_STEP_UP,
                                 RST_STEP_DOWN, RST_MAX_PRES};
  logic [PRES_W-1:0] pres_sh = '0;
  mode_t             mode_sh = MODE_NORMAL;

  brake_cmd_t brake_cmd_q[$];

  int n_ticks, n_faults, n_cmds, n_errs, stall_cycles;
  int n_settings = 1;
  bit tx_idle, rx_idle;
  int rx_hold;

  // Braking episode state for the random traffic
  int ep_vehicle, ep_req, ep_left, ep_fault_left;
  bit ep_ice;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic brake_cmd_t next_brake_cmd(input tick_t t);
    brake_cmd_t c;
    int w, v, req, p, slip, tgt, up, dn, mx;
    w    = int'(t.wheel);
    v    = int'(t.vehicle);
    req  = int'(t.req);
    up   = int'(regs_sh.step_up);
    dn   = int'(regs_sh.step_down);
    mx   = int'(regs_sh.max_pres);
    tgt  = t.ice ? int'(regs_sh.ice_tgt) : int'(regs_sh.normal_tgt);
    slip = 0;
    p    = int'(pres_sh);
    if (t.fault) begin
      mode_sh = MODE_FAULT;
    end else if (mode_sh == MODE_FAULT) begin
      mode_sh = MODE_RECOVERY;
    end
    if (mode_sh == MODE_FAULT) begin
      p = req;
    end else begin
      if (v > 0) begin
        slip = (100 * (v - w)) / v;
      end
      if (req == 0) begin
        p = 0;
      end else if (slip > tgt) begin
        p = p - dn;
      end else begin
        p = p + up;
      end
      // compare raw, report saturated
      if (slip < -100) begin
        slip = -100;
      end
    end
    if (p > req) p = req;
    if (p > mx) p = mx;
    if (p < 0) p = 0;
    pres_sh    = p[PRES_W-1:0];
    c.pressure = pres_sh;
    c.mode     = mode_sh;
    c.slip     = slip[SLIP_W-1:0];
    return c;
  endfunction

  function automatic tick_t tick_of(input int w, v, req, input bit ice, fault);
    tick_t t;
    t.wheel   = SPEED_BITS'(w);
    t.vehicle = SPEED_BITS'(v);
    t.req     = PRES_W'(req);
    t.ice     = ice;
    t.fault   = fault;
    return t;
  endfunction

  // Mostly plausible stops: falling vehicle speed, wheel slip around the
  // targets, short fault bursts; one tick in five is pure noise.
  function automatic tick_t make_tick();
    tick_t t;
    int slip, w;
    if ($urandom_range(0, 4) == 0) begin
      t.wheel   = SPEED_BITS'($urandom_range(0, SPD_MAX));
      t.vehicle = SPEED_BITS'($urandom_range(0, SPD_MAX));
      t.req     = PRES_W'($urandom_range(0, 255));
      t.ice     = $urandom_range(0, 1) == 1;
      t.fault   = $urandom_range(0, 7) == 0;
      return t;
    end
    if (ep_left == 0) begin
      ep_left    = $urandom_range(10, 40);
      ep_vehicle = $urandom_range(5, SPD_MAX);
      ep_req     = $urandom_range(1, 255);
      ep_ice     = $urandom_range(0, 1) == 1;
    end
    ep_left--;
    ep_vehicle -= $urandom_range(0, ep_vehicle / 16 + 1);
    if (ep_vehicle < 0) ep_vehicle = 0;
    case ($urandom_range(0, 9))
      0, 1:    slip = $urandom_range(31, 100);
      2:       slip = -int'($urandom_range(1, 30));
      default: slip = $urandom_range(0, 30);
    endcase
    w = ep_vehicle - ep_vehicle * slip / 100;
    if (w > SPD_MAX) w = SPD_MAX;
    if (ep_fault_left == 0 && $urandom_range(0, 24) == 0) begin
      ep_fault_left = $urandom_range(1, 4);
    end
    t.fault = ep_fault_left != 0;
    if (ep_fault_left != 0) ep_fault_left--;
    t.wheel   = SPEED_BITS'(w);
    t.vehicle = SPEED_BITS'(ep_vehicle);
    t.req     = ($urandom_range(0, 19) == 0) ? '0 : PRES_W'(ep_req);
    t.ice     = ep_ice;
    return t;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errs++;
    if (n_errs <= MAX_PRINTS) begin
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic send_tick(input tick_t t);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_wheel_speed   <= t.wheel;
    in_vehicle_speed <= t.vehicle;
    in_brake_request <= t.req;
    in_ice_mode      <= t.ice;
    in_system_fault  <= t.fault;
    do @(posedge clk); while (!in_ready);
    brake_cmd_q.push_back(next_brake_cmd(t));
    n_ticks++;
    if (t.fault) n_faults++;
  endtask

  // Hold the input off until every command is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (brake_cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] n_tgt, i_tgt, up, dn, mx);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{CFG_NORMAL_TGT, CFG_ICE_TGT, CFG_STEP_UP, CFG_STEP_DOWN, CFG_MAX_PRES};
    val = '{n_tgt, i_tgt, up, dn, mx};
    for (int k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      case (idx[k])
        CFG_NORMAL_TGT: regs_sh.normal_tgt = val[k][TGT_W-1:0];
        CFG_ICE_TGT:    regs_sh.ice_tgt    = val[k][TGT_W-1:0];
        CFG_STEP_UP:    regs_sh.step_up    = val[k];
        CFG_STEP_DOWN:  regs_sh.step_down  = val[k];
        CFG_MAX_PRES:   regs_sh.max_pres   = val[k];
        default: ;
      endcase
    end
    // an index past the list must leave every register alone
    cfg_index <= CFG_MAX_PRES + CFG_IDX_W'($urandom_range(1, 3));
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_ticks(input int count);
    repeat (count) send_tick(make_tick());
    drain();
  endtask

  task automatic test_slip_edges();
    tx_idle = 1;
    rx_idle = 1;
    send_tick(tick_of(0, 0, 255, 0, 0));
    send_tick(tick_of(SPD_MAX, 0, 255, 0, 0));
    send_tick(tick_of(0, SPD_MAX, 255, 0, 0));
    send_tick(tick_of(SPD_MAX, 1, 255, 0, 0));
    send_tick(tick_of(SPD_MAX, SPD_MAX, 255, 1, 0));
    send_tick(tick_of(2, 3, 200, 0, 0));
    send_tick(tick_of(4, 3, 200, 0, 0));
    send_tick(tick_of(200, 100, 200, 0, 0));
    send_tick(tick_of(201, 100, 200, 0, 0));
    send_tick(tick_of(SPD_MAX, SPD_MAX - 1, 200, 0, 0));
    send_tick(tick_of(90, 100, 255, 0, 0));
    send_tick(tick_of(90, 100, 255, 1, 0));
    send_tick(tick_of(85, 100, 255, 0, 0));
    send_tick(tick_of(0, 100, 0, 0, 0));
    drain();
  endtask

  task automatic test_fault_recovery();
    send_tick(tick_of(50, 100, 200, 0, 1));
    send_tick(tick_of(50, 100, 0, 0, 1));
    send_tick(tick_of(0, SPD_MAX, 255, 1, 1));
    send_tick(tick_of(100, 100, 255, 0, 0));
    send_tick(tick_of(100, 100, 255, 0, 0));
    send_tick(tick_of(0, 500, 180, 0, 1));
    send_tick(tick_of(0, 500, 0, 0, 0));
    send_tick(tick_of(0, 500, 100, 0, 0));
    drain();
  endtask

  task automatic test_register_extremes();
    write_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_ticks(30);
    // targets above 100: no step down ever
    write_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_ticks(30);
    write_regs(8'd100, 8'd100, 8'd1, 8'd1, 8'd128);
    run_ticks(30);
    write_regs(8'h80, 8'd1, 8'hFF, 8'hFF, 8'd1);
    run_ticks(30);
    write_regs(RST_NORMAL_TGT, RST_ICE_TGT, RST_STEP_UP, RST_STEP_DOWN, RST_MAX_PRES);
    run_ticks(20);
  endtask

  // Freeze the result side so the block fills up and pushes back on the input
  task automatic test_output_stall();
    tx_idle = 0;
    rx_idle = 0;
    rx_hold = HOLD_CYCLES;
    run_ticks(8);
  endtask

  task automatic test_random_braking();
    for (int seg = 0; seg < 12; seg++) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if (seg != 0 && $urandom_range(0, 1) == 1) begin
        write_regs(CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                            : $urandom_range(0, 40)),
                   CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                            : $urandom_range(0, 20)),
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom_range(60, 255)));
      end
      run_ticks(36);
    end
  endtask

  initial begin : result_side
    int gap;
    forever begin
      if (rx_hold != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin : check_cmds
    brake_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (brake_cmd_q.size() == 0) begin
        report_mismatch("unexpected result, pressure", int'(out_pressure), 0);
      end else begin
        want = brake_cmd_q.pop_front();
        n_cmds++;
        if (out_pressure !== want.pressure) begin
          report_mismatch("pressure", int'(out_pressure), int'(want.pressure));
        end
        if (out_abs_mode !== want.mode) begin
          report_mismatch("abs_mode", int'(out_abs_mode), int'(want.mode));
        end
        if (out_slip_percent !== want.slip) begin
          report_mismatch("slip_percent", int'(out_slip_percent), int'(want.slip));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_slip_edges();
    test_fault_recovery();
    test_register_extremes();
    test_output_stall();
    test_random_braking();
    drain();
    $display("Sent %0d control ticks (%0d under fault) across %0d register settings,",
             n_ticks, n_faults, n_settings);
    $display("checked %0d commands with random gaps, output stalls and a full input stall.",
             n_cmds);
    if (n_errs == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* abs_brake_pressure_step.f */
hw/rtl/abps_pkg.sv
hw/rtl/abps_cfg.sv
hw/rtl/abps_div.sv
hw/rtl/abs_brake_pressure_step.sv
dv/tb_abs_brake_pressure_step.sv
